[rtl/heightmap_cross_mean_filter_defines.svh]
// Assertion macros used by the height map filter back end.
`ifndef HEIGHTMAP_CROSS_MEAN_FILTER_DEFINES_SVH
`define HEIGHTMAP_CROSS_MEAN_FILTER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HCMF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HCMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define HCMF_ASSERT(label, clk, rst_n, prop, msg)
`define HCMF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

[rtl/hcmf_pkg.sv]
// Types, constants and register codes of the height map cross mean filter.
package hcmf_pkg;
	localparam int CFG_W       = 11;
	localparam int CFG_INDEX_W = 1;
	localparam int SAMPLE_W    = 8;
	localparam int SUM_W       = 11;
	localparam int CNT_W       = 3;
	localparam int PROD_W      = 21;

	localparam int DEF_MAX_ROW_LENGTH = 1024;
	localparam int DEF_MAX_ROW_COUNT  = 1024;

	localparam logic [CFG_W-1:0] ROW_LENGTH_RESET = 11'd1024;
	localparam logic [CFG_W-1:0] ROW_COUNT_RESET  = 11'd1024;

	localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT  = 1'b1;

	localparam logic ACTION_PIXEL = 1'b0;
	localparam logic ACTION_DRAIN = 1'b1;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam int RECIP3       = 683;
	localparam int RECIP3_SHIFT = 11;
	localparam int RECIP5       = 1639;
	localparam int RECIP5_SHIFT = 13;

	typedef struct packed {
		logic                action;
		logic [SAMPLE_W-1:0] height_sample;
	} hcmf_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] smoothed_height;
		logic                frame_done;
	} hcmf_out_t;

	typedef struct packed {
		logic drain;
		logic produce;
		logic has_up;
		logic has_left;
		logic has_right;
		logic last;
	} hcmf_cmd_t;
endpackage

[rtl/hcmf_ram.sv]
// Generic single write, single read RAM with registered read data.
module hcmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/hcmf_queue.sv]
// Small first-in first-out queue of register entries.
module hcmf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(do_push) - CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= wdata;
		end
	end
endmodule

[rtl/hcmf_front.sv]
// Front end: configuration registers, request classification and raster counters.
module hcmf_front #(
	parameter int MAX_ROW_LENGTH = 1024,
	parameter int MAX_ROW_COUNT  = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  hcmf_pkg::hcmf_in_t                item,
	output logic                              full,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hcmf_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [hcmf_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              cmd_full,
	output logic                              cmd_push,
	output hcmf_pkg::hcmf_cmd_t               cmd_flags,
	output logic [$clog2(MAX_ROW_LENGTH)-1:0] cmd_addr,
	output logic [hcmf_pkg::SAMPLE_W-1:0]     cmd_sample
);
	import hcmf_pkg::*;

	localparam int AW  = $clog2(MAX_ROW_LENGTH);
	localparam int LW  = $clog2(MAX_ROW_LENGTH + 1);
	localparam int RW  = $clog2(MAX_ROW_COUNT + 1);
	localparam int CLW = (LW > CFG_W) ? LW : CFG_W;
	localparam int CRW = (RW > CFG_W) ? RW : CFG_W;

	logic [CFG_W-1:0] row_length_q;
	logic [CFG_W-1:0] row_count_q;
	logic [AW-1:0]    col_pos_q;
	logic [AW-1:0]    drain_pos_q;
	logic [RW-1:0]    row_pos_q;
	logic [CLW-1:0]   len_ext;
	logic [CRW-1:0]   cnt_ext;
	logic [LW-1:0]    width_eff;
	logic [RW-1:0]    height_eff;
	logic [LW-1:0]    col_next;
	logic [LW-1:0]    drain_next;
	logic             row_end;
	logic             drain_last;
	logic             frame_in;
	logic             is_drain;
	logic             accept;
	logic             take;

	always_comb begin
		len_ext = CLW'(row_length_q);
		priority if (len_ext < CLW'(2)) begin
			width_eff = LW'(2);
		end else if (len_ext > CLW'(MAX_ROW_LENGTH)) begin
			width_eff = LW'(MAX_ROW_LENGTH);
		end else begin
			width_eff = LW'(len_ext);
		end
	end

	always_comb begin
		cnt_ext = CRW'(row_count_q);
		priority if (cnt_ext < CRW'(2)) begin
			height_eff = RW'(2);
		end else if (cnt_ext > CRW'(MAX_ROW_COUNT)) begin
			height_eff = RW'(MAX_ROW_COUNT);
		end else begin
			height_eff = RW'(cnt_ext);
		end
	end

	assign col_next   = LW'(col_pos_q) + LW'(1);
	assign drain_next = LW'(drain_pos_q) + LW'(1);
	assign row_end    = (col_next >= width_eff);
	assign drain_last = (drain_next >= width_eff);
	assign frame_in   = (row_pos_q >= height_eff);
	assign is_drain   = (item.action == ACTION_DRAIN);

	assign full      = cmd_full;
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;
	// drop drains before the frame is in and pixels once it is
	assign take      = accept && (is_drain == frame_in);
	assign cmd_push  = take;

	always_comb begin
		cmd_flags.drain     = is_drain;
		cmd_flags.produce   = is_drain || (row_pos_q >= RW'(1));
		cmd_flags.has_up    = is_drain || (row_pos_q >= RW'(2));
		cmd_flags.has_left  = is_drain ? (drain_pos_q != '0) : (col_pos_q != '0);
		cmd_flags.has_right = is_drain ? !drain_last : !row_end;
		cmd_flags.last      = is_drain && drain_last;
		cmd_addr            = is_drain ? drain_pos_q : col_pos_q;
		cmd_sample          = item.height_sample;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROW_LENGTH_RESET;
			row_count_q  <= ROW_COUNT_RESET;
			col_pos_q    <= '0;
			drain_pos_q  <= '0;
			row_pos_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ROW_LENGTH: row_length_q <= cfg_data;
					REG_ROW_COUNT:  row_count_q  <= cfg_data;
				endcase
			end
			if (take) begin
				if (is_drain) begin
					if (drain_last) begin
						drain_pos_q <= '0;
						row_pos_q   <= '0;
						col_pos_q   <= '0;
					end else begin
						drain_pos_q <= AW'(drain_next);
					end
				end else begin
					if (row_end) begin
						col_pos_q <= '0;
						row_pos_q <= row_pos_q + RW'(1);
					end else begin
						col_pos_q <= AW'(col_next);
					end
				end
			end
		end
	end
endmodule

[rtl/hcmf_back.sv]
// Back end: line stores, neighbour sum, constant divide and result queue.
`include "heightmap_cross_mean_filter_defines.svh"
module hcmf_back #(
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_empty,
	output logic                              cmd_pop,
	input  hcmf_pkg::hcmf_cmd_t               cmd_flags,
	input  logic [$clog2(MAX_ROW_LENGTH)-1:0] cmd_addr,
	input  logic [hcmf_pkg::SAMPLE_W-1:0]     cmd_sample,
	output logic                              empty,
	input  logic                              pop,
	output hcmf_pkg::hcmf_out_t               result
);
	import hcmf_pkg::*;

	localparam int AW = $clog2(MAX_ROW_LENGTH);
	localparam int OW = $clog2(OUT_DEPTH + 1);
	localparam int RW = $bits(hcmf_out_t);

	logic                issue;
	logic [AW-1:0]       right_addr;
	logic                valid_s1;
	hcmf_cmd_t           flags_s1;
	logic [AW-1:0]       addr_s1;
	logic [AW-1:0]       right_addr_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                write_s1;
	logic [SAMPLE_W-1:0] center_rd;
	logic [SAMPLE_W-1:0] right_rd;
	logic [SAMPLE_W-1:0] up_rd;
	logic [SAMPLE_W-1:0] center;
	logic [SAMPLE_W-1:0] right;
	logic [SAMPLE_W-1:0] up;
	logic [SAMPLE_W-1:0] left;
	logic                wr_valid_q;
	logic [AW-1:0]       wr_addr_q;
	logic [SAMPLE_W-1:0] wr_recent_q;
	logic [SAMPLE_W-1:0] wr_older_q;
	logic [SAMPLE_W-1:0] hold_q;
	logic [SAMPLE_W-1:0] drain_left_q;
	logic [AW-1:0]       drain_left_addr_q;
	logic [SUM_W-1:0]    sum;
	logic [CNT_W-1:0]    cnt;
	logic                valid_s2;
	logic [SUM_W-1:0]    sum_s2;
	logic [CNT_W-1:0]    cnt_s2;
	logic                last_s2;
	logic [PROD_W-1:0]   prod3;
	logic [PROD_W-1:0]   prod5;
	logic [SAMPLE_W-1:0] quot;
	logic [OW-1:0]       outstanding_q;
	hcmf_out_t           out_entry;
	logic [RW-1:0]       out_rdata;
	logic                out_push;
	logic                out_full;
	logic                out_pop;

	// issue only with a result slot reserved, so the pipeline never stalls
	assign issue      = !cmd_empty && (outstanding_q < OW'(OUT_DEPTH));
	assign cmd_pop    = issue;
	assign right_addr = cmd_addr + AW'(1);
	assign write_s1   = valid_s1 && !flags_s1.drain;

	hcmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_recent_centre (
		.clk   (clk),
		.we    (write_s1),
		.waddr (addr_s1),
		.wdata (sample_s1),
		.re    (issue),
		.raddr (cmd_addr),
		.rdata (center_rd)
	);

	hcmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_recent_right (
		.clk   (clk),
		.we    (write_s1),
		.waddr (addr_s1),
		.wdata (sample_s1),
		.re    (issue),
		.raddr (right_addr),
		.rdata (right_rd)
	);

	hcmf_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW_LENGTH)) u_older (
		.clk   (clk),
		.we    (write_s1),
		.waddr (addr_s1),
		.wdata (center),
		.re    (issue),
		.raddr (cmd_addr),
		.rdata (up_rd)
	);

	// bypass the write that landed on the same edge as the read
	assign center = (wr_valid_q && wr_addr_q == addr_s1) ? wr_recent_q : center_rd;
	assign right  = (wr_valid_q && wr_addr_q == right_addr_s1) ? wr_recent_q : right_rd;
	assign up     = (wr_valid_q && wr_addr_q == addr_s1) ? wr_older_q : up_rd;
	assign left   = flags_s1.drain ? drain_left_q : hold_q;

	always_comb begin
		sum = SUM_W'(center)
			+ (flags_s1.has_up ? SUM_W'(up) : '0)
			+ (!flags_s1.drain ? SUM_W'(sample_s1) : '0)
			+ (flags_s1.has_left ? SUM_W'(left) : '0)
			+ (flags_s1.has_right ? SUM_W'(right) : '0);
		cnt = CNT_W'(1)
			+ CNT_W'(flags_s1.has_up)
			+ CNT_W'(!flags_s1.drain)
			+ CNT_W'(flags_s1.has_left)
			+ CNT_W'(flags_s1.has_right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			wr_valid_q    <= 1'b0;
			outstanding_q <= '0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1 && flags_s1.produce;
			if (write_s1) begin
				wr_valid_q <= 1'b1;
			end
			outstanding_q <= outstanding_q + OW'(issue && cmd_flags.produce) - OW'(out_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			flags_s1      <= cmd_flags;
			addr_s1       <= cmd_addr;
			right_addr_s1 <= right_addr;
			sample_s1     <= cmd_sample;
		end
		if (write_s1) begin
			wr_addr_q   <= addr_s1;
			wr_recent_q <= sample_s1;
			wr_older_q  <= center;
		end
		if (valid_s1 && flags_s1.produce && !flags_s1.drain) begin
			hold_q <= center;
		end
		if (valid_s1 && flags_s1.drain) begin
			drain_left_q      <= center;
			drain_left_addr_q <= addr_s1;
		end else if (write_s1 && drain_left_addr_q == addr_s1) begin
			drain_left_q <= sample_s1;
		end
		if (valid_s1 && flags_s1.produce) begin
			sum_s2  <= sum;
			cnt_s2  <= cnt;
			last_s2 <= flags_s1.last;
		end
	end

	assign prod3 = PROD_W'(sum_s2) * PROD_W'(RECIP3);
	assign prod5 = PROD_W'(sum_s2) * PROD_W'(RECIP5);

	always_comb begin
		unique case (cnt_s2)
			CNT_W'(3): quot = SAMPLE_W'(prod3 >> RECIP3_SHIFT);
			CNT_W'(4): quot = SAMPLE_W'(sum_s2 >> 2);
			default:   quot = SAMPLE_W'(prod5 >> RECIP5_SHIFT);
		endcase
	end

	assign out_entry.smoothed_height = quot;
	assign out_entry.frame_done      = last_s2;
	assign out_push                  = valid_s2;
	assign out_pop                   = pop && !empty;
	assign result                    = hcmf_out_t'(out_rdata);

	hcmf_queue #(.WIDTH(RW), .DEPTH(OUT_DEPTH)) u_result_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (RW'(out_entry)),
		.full   (out_full),
		.pop    (out_pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	`HCMF_ASSERT_IMPL(a_result_room, clk, arst_n, out_push, !out_full, "result queue overflow")
	`HCMF_ASSERT(a_credit_bound, clk, arst_n, outstanding_q <= OW'(OUT_DEPTH), "credit overrun")
	`HCMF_ASSERT_IMPL(a_pop_tracked, clk, arst_n, out_pop, outstanding_q != '0, "untracked pop")
	`HCMF_ASSERT_IMPL(a_divisor, clk, arst_n, valid_s2, cnt_s2 == CNT_W'(3) || cnt_s2 == CNT_W'(4) || cnt_s2 == CNT_W'(5), "divisor outside three to five")
endmodule

[rtl/heightmap_cross_mean_filter.sv]
// Height map cross mean filter: one pixel per clock in and out while full and
// empty stay low, in raster order. Pixels (action 0) are taken at one per cycle
// while full is low; each result is the truncated mean of a pixel and its
// in-image up, down, left and right neighbours, so row r comes out while row
// r+1 goes in, and row 0 gives nothing. After the last pixel of a frame, send
// one drain request (action 1) per column to get the final row; its last result
// has frame_done set. Drains before the frame is complete and pixels during the
// drain are dropped. Throughput is one request per cycle while a result slot is
// free, set by the single write port of each line store, which takes one write
// per pixel. Line stores are not cleared after reset. Register 0 is
// row_length, register 1 is row_count; both are clamped to 2..MAX. They must
// be written only while no request is in flight; the block does not enforce it.
module heightmap_cross_mean_filter #(
	parameter int MAX_ROW_LENGTH = hcmf_pkg::DEF_MAX_ROW_LENGTH,
	parameter int MAX_ROW_COUNT  = hcmf_pkg::DEF_MAX_ROW_COUNT
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  hcmf_pkg::hcmf_in_t               item,
	output logic                             full,
	output logic                             empty,
	input  logic                             pop,
	output hcmf_pkg::hcmf_out_t              result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [hcmf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hcmf_pkg::CFG_W-1:0]       cfg_data
);
	import hcmf_pkg::*;

	localparam int AW   = $clog2(MAX_ROW_LENGTH);
	localparam int CMDW = $bits(hcmf_cmd_t) + AW + SAMPLE_W;

	logic                cmd_push;
	logic                cmd_full;
	hcmf_cmd_t           front_flags;
	logic [AW-1:0]       front_addr;
	logic [SAMPLE_W-1:0] front_sample;
	logic [CMDW-1:0]     cmd_wdata;
	logic [CMDW-1:0]     cmd_rdata;
	logic                cmd_empty;
	logic                cmd_pop;
	hcmf_cmd_t           back_flags;
	logic [AW-1:0]       back_addr;
	logic [SAMPLE_W-1:0] back_sample;

	hcmf_front #(
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH),
		.MAX_ROW_COUNT  (MAX_ROW_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.item       (item),
		.full       (full),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd_flags  (front_flags),
		.cmd_addr   (front_addr),
		.cmd_sample (front_sample)
	);

	assign cmd_wdata = {front_flags, front_addr, front_sample};

	hcmf_queue #(.WIDTH(CMDW), .DEPTH(CMD_DEPTH)) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wdata),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign {back_flags, back_addr, back_sample} = cmd_rdata;

	hcmf_back #(.MAX_ROW_LENGTH(MAX_ROW_LENGTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.cmd_flags  (back_flags),
		.cmd_addr   (back_addr),
		.cmd_sample (back_sample),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);
endmodule

[tb/tb_top.sv]
// Self-checking bench for the height map cross mean filter: random frames and idling.
`timescale 1ns / 1ps

module tb_top;
	import hcmf_pkg::*;

	localparam int LINE_AW = $clog2(DEF_MAX_ROW_LENGTH);

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   push      = 1'b0;
	hcmf_in_t               item      = '0;
	logic                   full;
	logic                   empty;
	logic                   pop       = 1'b0;
	hcmf_out_t              result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data  = '0;

	heightmap_cross_mean_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Filter state as the bench sees it
	logic [SAMPLE_W-1:0] older_line  [DEF_MAX_ROW_LENGTH];
	logic [SAMPLE_W-1:0] recent_line [DEF_MAX_ROW_LENGTH];
	int unsigned         col_pos   = 0;
	int unsigned         row_pos   = 0;
	int unsigned         drain_pos = 0;
	logic [SAMPLE_W-1:0] left_hold = '0;
	logic [CFG_W-1:0]    width_reg  = ROW_LENGTH_RESET;
	logic [CFG_W-1:0]    height_reg = ROW_COUNT_RESET;

	hcmf_in_t  pixel_stream [$];
	hcmf_out_t smoothed_due [$];

	int unsigned queued_total   = 0;
	int unsigned accepted_total = 0;
	int unsigned checked_total  = 0;
	int unsigned settings_done  = 0;
	int unsigned frames_sent    = 0;
	int unsigned errors         = 0;

	function automatic int unsigned span(logic [CFG_W-1:0] v, int unsigned hi);
		int unsigned u;
		u = 32'(v);
		if (u < 2)
			return 2;
		if (u > hi)
			return hi;
		return u;
	endfunction

	function automatic int unsigned idle_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic void filter_step(hcmf_in_t req);
		int unsigned         w;
		int unsigned         h;
		int unsigned         c;
		int unsigned         d;
		int unsigned         sum;
		int unsigned         cnt;
		bit                  frame_in;
		bit                  last;
		logic [SAMPLE_W-1:0] centre;
		hcmf_out_t           mean;
		w = span(width_reg, DEF_MAX_ROW_LENGTH);
		h = span(height_reg, DEF_MAX_ROW_COUNT);
		frame_in = row_pos >= h;
		if (req.action == ACTION_PIXEL) begin
			if (frame_in)
				return;
			c = col_pos;
			if (row_pos >= 1) begin
				centre = recent_line[LINE_AW'(c)];
				sum = 32'(centre);
				cnt = 1;
				if (row_pos >= 2) begin
					sum += 32'(older_line[LINE_AW'(c)]);
					cnt++;
				end
				sum += 32'(req.height_sample);
				cnt++;
				if (c > 0) begin
					sum += 32'(left_hold);
					cnt++;
				end
				if (c + 1 < w) begin
					sum += 32'(recent_line[LINE_AW'(c + 1)]);
					cnt++;
				end
				mean.smoothed_height = SAMPLE_W'(sum / cnt);
				mean.frame_done = 1'b0;
				smoothed_due = {smoothed_due, mean};
				left_hold = centre;
			end
			older_line[LINE_AW'(c)] = recent_line[LINE_AW'(c)];
			recent_line[LINE_AW'(c)] = req.height_sample;
			if (c + 1 >= w) begin
				col_pos = 0;
				row_pos++;
			end else begin
				col_pos = c + 1;
			end
			return;
		end
		if (!frame_in)
			return;
		d = drain_pos;
		last = d + 1 >= w;
		sum = 32'(recent_line[LINE_AW'(d)]);
		sum += 32'(older_line[LINE_AW'(d)]);
		cnt = 2;
		if (d > 0) begin
			sum += 32'(recent_line[LINE_AW'(d - 1)]);
			cnt++;
		end
		if (!last) begin
			sum += 32'(recent_line[LINE_AW'(d + 1)]);
			cnt++;
		end
		mean.smoothed_height = SAMPLE_W'(sum / cnt);
		mean.frame_done = last;
		smoothed_due = {smoothed_due, mean};
		if (last) begin
			drain_pos = 0;
			row_pos = 0;
			col_pos = 0;
			left_hold = '0;
		end else begin
			drain_pos = d + 1;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Driver
	int unsigned tx_gap  = 0;
	int unsigned tx_run  = 0;
	bit          tx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			item <= '0;
		end else begin
			if (push && !full) begin
				filter_step(item);
				accepted_total++;
			end
			if (!push || !full) begin
				if (tx_gap > 0) begin
					tx_gap--;
					push <= 1'b0;
				end else if (pixel_stream.size() > 0) begin
					item <= pixel_stream.pop_front();
					push <= 1'b1;
					if (tx_run == 0) begin
						tx_calm = $urandom_range(0, 3) == 0;
						tx_run = $urandom_range(10, 150);
					end
					tx_run--;
					tx_gap = idle_gap(tx_calm);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor
	int unsigned rx_stall = 0;
	int unsigned rx_run   = 0;
	bit          rx_calm  = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		hcmf_out_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (smoothed_due.size() == 0) begin
					$error("unexpected result: smoothed_height %0d, frame_done %0d",
						result.smoothed_height, result.frame_done);
					errors++;
				end else begin
					want = smoothed_due.pop_front();
					checked_total++;
					if (result.smoothed_height !== want.smoothed_height) begin
						$error("smoothed_height: expected %0d, actual %0d",
							want.smoothed_height, result.smoothed_height);
						errors++;
					end
					if (result.frame_done !== want.frame_done) begin
						$error("frame_done: expected %0d, actual %0d",
							want.frame_done, result.frame_done);
						errors++;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				pop <= 1'b0;
			end else if (pop && !empty) begin
				if (rx_run == 0) begin
					rx_calm = $urandom_range(0, 3) == 0;
					rx_run = $urandom_range(10, 150);
				end
				rx_run--;
				rx_stall = idle_gap(rx_calm);
				pop <= rx_stall == 0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic add_req(logic action, logic [SAMPLE_W-1:0] sample);
		hcmf_in_t req;
		req.action = action;
		req.height_sample = sample;
		pixel_stream = {pixel_stream, req};
		queued_total++;
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROW_LENGTH)
			width_reg = val;
		else
			height_reg = val;
		settings_done++;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (accepted_total != queued_total || smoothed_due.size() != 0);
		repeat (16) @(posedge clk);
	endtask

	// One whole frame at the current setting, with ignored requests mixed in
	task automatic queue_frame(int unsigned noise_pct);
		int unsigned         w;
		int unsigned         h;
		int unsigned         r;
		logic [SAMPLE_W-1:0] s;
		w = span(width_reg, DEF_MAX_ROW_LENGTH);
		h = span(height_reg, DEF_MAX_ROW_COUNT);
		for (int unsigned n = 0; n < w * h; n++) begin
			if ($urandom_range(0, 99) < noise_pct)
				add_req(ACTION_DRAIN, SAMPLE_W'($urandom));
			r = $urandom_range(0, 9);
			s = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : SAMPLE_W'($urandom_range(0, 255));
			add_req(ACTION_PIXEL, s);
		end
		for (int unsigned d = 0; d < w; d++) begin
			if ($urandom_range(0, 99) < noise_pct)
				add_req(ACTION_PIXEL, SAMPLE_W'($urandom));
			add_req(ACTION_DRAIN, SAMPLE_W'($urandom));
		end
		frames_sent++;
	endtask

	initial begin
		logic [CFG_W-1:0] len_val;
		logic [CFG_W-1:0] cnt_val;
		int unsigned      r;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// 3x3 frame: corners, edges and a full cross, plus early drain and late pixel
		write_reg(REG_ROW_LENGTH, 11'd3);
		write_reg(REG_ROW_COUNT, 11'd3);
		add_req(ACTION_DRAIN, 8'hA5);
		add_req(ACTION_PIXEL, 8'd0);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_PIXEL, 8'd0);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_DRAIN, 8'h5A);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_PIXEL, 8'd0);
		add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_PIXEL, 8'h5A);
		add_req(ACTION_DRAIN, 8'd0);
		add_req(ACTION_PIXEL, 8'hFF);
		add_req(ACTION_DRAIN, 8'd255);
		add_req(ACTION_DRAIN, 8'd0);
		add_req(ACTION_DRAIN, 8'hFF);
		wait_idle();

		// settings below range clamp to a 2x2 frame
		write_reg(REG_ROW_LENGTH, 11'd0);
		write_reg(REG_ROW_COUNT, 11'd1);
		repeat (4) add_req(ACTION_PIXEL, 8'd255);
		add_req(ACTION_DRAIN, 8'd0);
		add_req(ACTION_DRAIN, 8'd255);
		wait_idle();

		while (queued_total < 1850) begin
			r = $urandom_range(0, 19);
			len_val = (r == 0) ? CFG_W'($urandom_range(0, 1)) :
				(r < 4) ? CFG_W'($urandom_range(17, 48)) : CFG_W'($urandom_range(2, 12));
			r = $urandom_range(0, 19);
			cnt_val = (r == 0) ? CFG_W'($urandom_range(0, 1)) : CFG_W'($urandom_range(2, 6));
			if ($urandom_range(0, 1)) begin
				write_reg(REG_ROW_LENGTH, len_val);
				write_reg(REG_ROW_COUNT, cnt_val);
			end else begin
				write_reg(REG_ROW_COUNT, cnt_val);
				write_reg(REG_ROW_LENGTH, len_val);
			end
			repeat ($urandom_range(1, 3)) queue_frame($urandom_range(0, 8));
			wait_idle();
		end

		$display("summary: %0d requests in %0d frames, %0d means checked, %0d register writes",
			accepted_total, frames_sent, checked_total, settings_done);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("tb_top: errors");
		$finish;
	end
endmodule
